FILE: sv/hcb_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_pkg
// Shared constants and types of the Huffman code builder.
// ----------------------------------------------------------------------------
package hcb_pkg;

	localparam int MAX_SYMBOLS_DEF = 64;
	localparam int WEIGHT_BITS_DEF = 16;

	// result status codes
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_FULL    = 2'd1;
	localparam logic [1:0] ST_INVALID = 2'd2;

	localparam logic MODE_LOAD  = 1'b0;
	localparam logic MODE_QUERY = 1'b1;

	// control from the sequencer to the minimum scan unit
	typedef struct packed {
		logic clear;
		logic en;
	} scan_ctrl_t;

endpackage

FILE: sv/hcb_min_scan.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcb_min_scan
// Shared compare unit: tracks the lowest and second-lowest tree over a scan.
// ----------------------------------------------------------------------------
module hcb_min_scan #(
	parameter int NW = 22,
	parameter int SB = 6,
	parameter int NB = 7
) (
	input  logic               clk,
	input  logic               arst_n,
	input  hcb_pkg::scan_ctrl_t ctrl,
	input  logic [NW-1:0]      w,
	input  logic [SB-1:0]      slot,
	input  logic [NB-1:0]      node,
	output logic [NW-1:0]      lo_w,
	output logic [SB-1:0]      lo_slot,
	output logic [NB-1:0]      lo_node,
	output logic [NW-1:0]      sec_w,
	output logic [SB-1:0]      sec_slot,
	output logic [NB-1:0]      sec_node
);

	logic lo_v_q, sec_v_q;
	logic [NW-1:0] lo_w_q, sec_w_q;
	logic [SB-1:0] lo_slot_q, sec_slot_q;
	logic [NB-1:0] lo_node_q, sec_node_q;

	// valid flags: strict-less keeps the earlier tree on ties
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lo_v_q  <= 1'b0;
			sec_v_q <= 1'b0;
		end else if (ctrl.clear) begin
			lo_v_q  <= 1'b0;
			sec_v_q <= 1'b0;
		end else if (ctrl.en) begin
			if (!sec_v_q || w < sec_w_q) begin
				if (!lo_v_q || w < lo_w_q) begin
					if (lo_v_q) sec_v_q <= 1'b1;
					lo_v_q <= 1'b1;
				end else begin
					sec_v_q <= 1'b1;
				end
			end
		end
	end

	// candidate payload
	always_ff @(posedge clk) begin
		if (ctrl.en && !ctrl.clear) begin
			if (!sec_v_q || w < sec_w_q) begin
				if (!lo_v_q || w < lo_w_q) begin
					if (lo_v_q) begin
						sec_w_q    <= lo_w_q;
						sec_slot_q <= lo_slot_q;
						sec_node_q <= lo_node_q;
					end
					lo_w_q    <= w;
					lo_slot_q <= slot;
					lo_node_q <= node;
				end else begin
					sec_w_q    <= w;
					sec_slot_q <= slot;
					sec_node_q <= node;
				end
			end
		end
	end

	assign lo_w     = lo_w_q;
	assign lo_slot  = lo_slot_q;
	assign lo_node  = lo_node_q;
	assign sec_w    = sec_w_q;
	assign sec_slot = sec_slot_q;
	assign sec_node = sec_node_q;

`ifndef ASSERT_OFF
	a_sec_needs_lo: assert property (@(posedge clk) disable iff (!arst_n)
		sec_v_q |-> lo_v_q) else $error("second without lowest");
	a_order: assert property (@(posedge clk) disable iff (!arst_n)
		(lo_v_q && sec_v_q) |-> (lo_w_q <= sec_w_q)) else $error("lowest above second");
	a_clear: assert property (@(posedge clk) disable iff (!arst_n)
		ctrl.clear |=> (!lo_v_q && !sec_v_q)) else $error("clear failed");
`endif

endmodule

FILE: sv/huffman_code_builder_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// huffman_code_builder_unit
// Loads symbol weights, builds a Huffman tree and answers code queries.
// ----------------------------------------------------------------------------
// One word at a time. A load goes to RESP, which registers its result. A load
// marked last then builds the tree: each merge scans the n active trees
// through one compare unit, writes two parent links and closes the gap in the
// active list by moving each slot behind the removed tree down by one place.
// A query walks from the leaf to the root, one parent link per code bit.
// The input side is ready only while idle; results sit in an output register,
// and a finished result waits until that register is free.
module huffman_code_builder_unit #(
	parameter int MAX_SYMBOLS = hcb_pkg::MAX_SYMBOLS_DEF,
	parameter int WEIGHT_BITS = hcb_pkg::WEIGHT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [23:0] s_tdata,  // symbol_index[5:0], weight[21:6], zero pad
	input  logic [0:0]  s_tuser,  // mode
	input  logic        s_tlast,  // last
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [79:0] m_tdata   // status, code_length, code_bits, loaded_count
);

	localparam int SB = (MAX_SYMBOLS > 1) ? $clog2(MAX_SYMBOLS) : 1;
	localparam int CB = $clog2(MAX_SYMBOLS + 1);
	localparam int ND = 2 * MAX_SYMBOLS - 1;
	localparam int NB = $clog2(ND + 1);
	localparam int NW = WEIGHT_BITS + SB;

	typedef enum logic [3:0] {
		IDLE, SCAN, MERGE_L, MERGE_R, SHIFT_RD, SHIFT_WR, Q_RD, Q_WAIT, RESP
	} state_t;

	state_t state_q;
	logic [CB-1:0] total_q, active_q, scan_i_q, k_q;
	logic [NB-1:0] nfree_q, node_q, root_q;
	logic          tree_q, pend_s1;
	logic [SB-1:0] pend_slot_s1;
	logic [1:0]    status_q;
	logic [5:0]    len_q;
	logic [63:0]   bits_q;
	logic [6:0]    count_q;
	logic [1:0]    out_status_q;
	logic [5:0]    out_len_q;
	logic [63:0]   out_bits_q;

	// active list memories and node link memories
	logic [NW-1:0] aw_mem [MAX_SYMBOLS];
	logic [NB-1:0] an_mem [MAX_SYMBOLS];
	logic [NB-1:0] par_mem [ND];
	logic          isr_mem [ND];
	logic [NW-1:0] aw_rd_q;
	logic [NB-1:0] an_rd_q, par_rd_q;
	logic          isr_rd_q;

	logic [15:0]   w_in;
	logic [NW-1:0] w_ld, lo_w, sec_w, sum_w;
	logic [SB-1:0] lo_slot, sec_slot;
	logic [NB-1:0] lo_node, sec_node;
	logic [5:0]    sym_in;
	logic          accept, is_load;
	logic [CB-1:0] tot_eff, tot_new;
	logic          a_we;
	logic [SB-1:0] a_waddr, a_raddr;
	logic [NW-1:0] a_wd_w;
	logic [NB-1:0] a_wd_n;
	logic          p_we, p_wd_r;
	logic [NB-1:0] p_waddr;
	hcb_pkg::scan_ctrl_t sc;

	assign w_in    = s_tdata[21:6];
	assign sym_in  = s_tdata[5:0];
	assign accept  = s_tvalid && s_tready;
	assign is_load = (s_tuser[0] == hcb_pkg::MODE_LOAD);
	assign s_tready = (state_q == IDLE);
	assign sum_w   = lo_w + sec_w;
	assign tot_eff = tree_q ? '0 : total_q;
	assign tot_new = (tot_eff < CB'(MAX_SYMBOLS)) ? tot_eff + 1'b1 : tot_eff;

	generate
		if (WEIGHT_BITS >= 16) begin : g_wide
			assign w_ld = NW'(w_in);
		end else begin : g_narrow
			assign w_ld = NW'(w_in[WEIGHT_BITS-1:0]);
		end
	endgenerate

	// active list write port
	always_comb begin
		a_we    = 1'b0;
		a_waddr = k_q[SB-1:0];
		a_wd_w  = aw_rd_q;
		a_wd_n  = an_rd_q;
		unique case (state_q)
			IDLE: begin
				a_we    = accept && is_load && (tot_eff < CB'(MAX_SYMBOLS));
				a_waddr = tot_eff[SB-1:0];
				a_wd_w  = w_ld;
				a_wd_n  = NB'(tot_eff);
			end
			MERGE_L: begin
				a_we    = 1'b1;
				a_waddr = lo_slot;
				a_wd_w  = sum_w;
				a_wd_n  = nfree_q;
			end
			SHIFT_WR: a_we = 1'b1;
			default: a_we = 1'b0;
		endcase
	end

	assign a_raddr = (state_q == SCAN) ? scan_i_q[SB-1:0] : SB'(k_q + 1'b1);

	always_ff @(posedge clk) begin
		if (a_we) begin
			aw_mem[a_waddr] <= a_wd_w;
			an_mem[a_waddr] <= a_wd_n;
		end
		aw_rd_q <= aw_mem[a_raddr];
		an_rd_q <= an_mem[a_raddr];
	end

	// parent link port
	assign p_we    = (state_q == MERGE_L) || (state_q == MERGE_R);
	assign p_waddr = (state_q == MERGE_L) ? lo_node : sec_node;
	assign p_wd_r  = (state_q == MERGE_R);

	always_ff @(posedge clk) begin
		if (p_we) begin
			par_mem[p_waddr] <= nfree_q;
			isr_mem[p_waddr] <= p_wd_r;
		end
		par_rd_q <= par_mem[node_q];
		isr_rd_q <= isr_mem[node_q];
	end

	// compare unit control
	assign sc.clear = (state_q == IDLE) || (state_q == SHIFT_RD);
	assign sc.en    = (state_q == SCAN) && pend_s1;

	hcb_min_scan #(.NW(NW), .SB(SB), .NB(NB)) u_scan (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctrl     (sc),
		.w        (aw_rd_q),
		.slot     (pend_slot_s1),
		.node     (an_rd_q),
		.lo_w     (lo_w),
		.lo_slot  (lo_slot),
		.lo_node  (lo_node),
		.sec_w    (sec_w),
		.sec_slot (sec_slot),
		.sec_node (sec_node)
	);

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= IDLE;
			total_q      <= '0;
			active_q     <= '0;
			scan_i_q     <= '0;
			k_q          <= '0;
			nfree_q      <= '0;
			node_q       <= '0;
			root_q       <= '0;
			tree_q       <= 1'b0;
			pend_s1      <= 1'b0;
			pend_slot_s1 <= '0;
			status_q     <= hcb_pkg::ST_OK;
			len_q        <= '0;
			bits_q       <= '0;
			count_q      <= '0;
			out_status_q <= hcb_pkg::ST_OK;
			out_len_q    <= '0;
			out_bits_q   <= '0;
			m_tvalid     <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) m_tvalid <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						status_q <= hcb_pkg::ST_OK;
						len_q    <= '0;
						bits_q   <= '0;
						if (is_load) begin
							if (tot_eff == CB'(MAX_SYMBOLS)) status_q <= hcb_pkg::ST_FULL;
							total_q <= tot_new;
							tree_q  <= 1'b0;
							nfree_q <= NB'(tot_eff);
							if (s_tlast) begin
								active_q <= tot_new;
								nfree_q  <= NB'(tot_new);
								scan_i_q <= '0;
								pend_s1  <= 1'b0;
								if (tot_new > CB'(1)) begin
									state_q <= SCAN;
								end else begin
									tree_q  <= 1'b1;
									state_q <= RESP;
								end
							end else begin
								state_q <= RESP;
							end
						end else if (!tree_q || {1'b0, sym_in} >= 7'(total_q)) begin
							status_q <= hcb_pkg::ST_INVALID;
							state_q  <= RESP;
						end else begin
							node_q  <= NB'(sym_in);
							root_q  <= (total_q == CB'(1)) ? '0 : nfree_q - 1'b1;
							state_q <= Q_RD;
						end
					end
				end
				SCAN: begin
					if (scan_i_q < active_q) begin
						pend_s1      <= 1'b1;
						pend_slot_s1 <= scan_i_q[SB-1:0];
						scan_i_q     <= scan_i_q + 1'b1;
					end else begin
						pend_s1 <= 1'b0;
						if (!pend_s1) state_q <= MERGE_L;
					end
				end
				MERGE_L: state_q <= MERGE_R;
				MERGE_R: begin
					k_q     <= CB'(sec_slot);
					state_q <= SHIFT_RD;
				end
				SHIFT_RD: begin
					if (k_q + 1'b1 < active_q) begin
						state_q <= SHIFT_WR;
					end else begin
						active_q <= active_q - 1'b1;
						nfree_q  <= nfree_q + 1'b1;
						scan_i_q <= '0;
						if (active_q - 1'b1 > CB'(1)) begin
							state_q <= SCAN;
						end else begin
							tree_q  <= 1'b1;
							state_q <= RESP;
						end
					end
				end
				SHIFT_WR: begin
					k_q     <= k_q + 1'b1;
					state_q <= SHIFT_RD;
				end
				Q_RD: begin
					if (node_q != root_q && len_q < 6'd63) state_q <= Q_WAIT;
					else state_q <= RESP;
				end
				Q_WAIT: begin
					bits_q[len_q] <= isr_rd_q;
					len_q         <= len_q + 1'b1;
					node_q        <= par_rd_q;
					state_q       <= Q_RD;
				end
				// hold the result until the output register is free
				RESP: begin
					if (!m_tvalid || m_tready) begin
						m_tvalid     <= 1'b1;
						count_q      <= 7'(total_q);
						out_status_q <= status_q;
						out_len_q    <= len_q;
						out_bits_q   <= bits_q;
						state_q      <= IDLE;
					end
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign m_tdata = {1'b0, count_q, out_bits_q, out_len_q, out_status_q};

`ifndef ASSERT_OFF
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> !s_tready) else $error("ready while busy");
	a_active: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == SCAN) |-> (active_q <= total_q && active_q > CB'(1)))
		else $error("active count out of range");
	a_total: assert property (@(posedge clk) disable iff (!arst_n)
		total_q <= CB'(MAX_SYMBOLS)) else $error("symbol count overflow");
`endif

endmodule
